### rtl/core/sed_pkg.sv
// Shared types and constants for the Sobel edge threshold block.
package sed_pkg;

  // Default sizes handed to the top-level parameters
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int PIXEL_BITS_DEF = 8;

  // Configuration register map
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_DIM_W  = 9;
  localparam int THRESH_W   = 11;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 9'd174;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 9'd144;
  localparam logic [THRESH_W-1:0]  THRESH_RST = 11'd150;

  // Result magnitude field
  localparam int MAG_W   = 11;
  localparam int MAG_MAX = 2047;
  localparam int OUT_DATA_W = 16;

  // Per-pixel control carried along the pipeline
  typedef struct packed {
    logic valid;
    logic emit;    // pixel completes an interior window
    logic last;    // last interior result of the frame
  } stg_ctrl_t;

  // One result transaction
  typedef struct packed {
    logic             frame_end;
    logic [MAG_W-1:0] magnitude;
    logic             edge_res;
  } res_t;

endpackage

### rtl/core/sed_line_mem.sv
// Two-row line buffer RAM with registered read, write-first bypass and power-up clear.
module sed_line_mem
  import sed_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic [2*PIXEL_BITS-1:0]      rd_data,   // {row two above, row above}
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [2*PIXEL_BITS-1:0]      wr_data,
  output logic                         clearing
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int DW = 2 * PIXEL_BITS;

  logic [DW-1:0] mem [MAX_WIDTH];
  logic [DW-1:0] rd_data_r;
  logic [AW-1:0] clr_cnt_r;
  logic          clearing_r;

  logic          we;
  logic [AW-1:0] wa;
  logic [DW-1:0] wd;

  // Clear sweep owns the write port until every row is zero
  assign we = clearing_r || wr_en;
  assign wa = clearing_r ? clr_cnt_r : wr_addr;
  assign wd = clearing_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clearing_r <= 1'b1;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(MAX_WIDTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Read with bypass of a same-cycle write to the same row
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (we && (wa == rd_addr)) begin
        rd_data_r <= wd;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule

### rtl/core/sed_window.sv
// 3x3 window, Sobel gradient sums, magnitude and threshold compare.
module sed_window
  import sed_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  stg_ctrl_t             s1_ctrl,
  input  logic [PIXEL_BITS-1:0] px,
  input  logic [PIXEL_BITS-1:0] above,
  input  logic [PIXEL_BITS-1:0] above2,
  input  logic [THRESH_W-1:0]   thresh,
  output logic                  res_valid,
  output res_t                  res
);

  localparam int GW = PIXEL_BITS + 3;                 // signed gradient width
  localparam int XW = (GW > MAG_W) ? GW : MAG_W;      // compare width

  logic [PIXEL_BITS-1:0] win_r [3][3];   // [row][col], row 0 oldest, col 2 newest

  logic s2_valid_r, s2_last_r;
  logic s3_valid_r, s3_last_r;
  logic signed [GW-1:0] gx_r, gy_r;

  logic [GW-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
  logic [GW-1:0] gx_abs, gy_abs, mag;
  logic [XW-1:0] mag_x;

  // Window shift: new column from the two stored rows and the incoming pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (adv && s1_ctrl.valid) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= above2;
      win_r[1][2] <= above;
      win_r[2][2] <= px;
    end
  end

  // Weighted column and row sums, weights 1,2,1
  always_comb begin
    gx_pos = GW'(win_r[0][2]) + (GW'(win_r[1][2]) << 1) + GW'(win_r[2][2]);
    gx_neg = GW'(win_r[0][0]) + (GW'(win_r[1][0]) << 1) + GW'(win_r[2][0]);
    gy_pos = GW'(win_r[2][0]) + (GW'(win_r[2][1]) << 1) + GW'(win_r[2][2]);
    gy_neg = GW'(win_r[0][0]) + (GW'(win_r[0][1]) << 1) + GW'(win_r[0][2]);
  end

  // Stage 2 marks a full window; stage 3 holds the gradients
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_ctrl.valid && s1_ctrl.emit;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last_r <= s1_ctrl.last;
      s3_last_r <= s2_last_r;
      gx_r      <= $signed(gx_pos - gx_neg);
      gy_r      <= $signed(gy_pos - gy_neg);
    end
  end

  // |Gx| + |Gy|, saturated for the port, unsaturated for the compare
  always_comb begin
    gx_abs = gx_r[GW-1] ? GW'(-gx_r) : GW'(gx_r);
    gy_abs = gy_r[GW-1] ? GW'(-gy_r) : GW'(gy_r);
    mag    = gx_abs + gy_abs;
    mag_x  = XW'(mag);
    res.edge_res  = mag_x > XW'(thresh);
    res.magnitude = (mag_x > XW'(MAG_MAX)) ? MAG_W'(MAG_MAX) : mag_x[MAG_W-1:0];
    res.frame_end = s3_last_r;
  end

  assign res_valid = s3_valid_r;

endmodule

### rtl/core/sed_out_buf.sv
// Output register with one skid entry so results can wait while pixels keep flowing.
module sed_out_buf
  import sed_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  res_t push_data,
  output logic room,
  output logic out_valid,
  output res_t out_data,
  input  logic out_ready
);

  logic out_valid_r, skid_valid_r;
  res_t out_data_r, skid_data_r;
  logic pop, out_free;

  assign pop      = out_valid_r && out_ready;
  assign out_free = !out_valid_r || pop;
  assign room     = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (skid_valid_r) begin
        // No push is taken while the skid entry is full
        if (out_free) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (push_valid) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end else begin
        // idle: hold
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) begin
        out_data_r <= skid_data_r;
      end
    end else if (push_valid) begin
      if (out_free) begin
        out_data_r <= push_data;
      end else begin
        skid_data_r <= push_data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/sobel_edge_threshold.sv
// Top level: Sobel 3x3 edge detector with threshold on a raster pixel stream.
//
//  Channel | Direction | Handshake         | Payload
//  --------+-----------+-------------------+------------------------------------------
//  in_     | slave     | tvalid / tready   | tdata: pixel; tuser: frame_start
//  out_    | master    | tvalid / tready   | tdata: edge_res, magnitude; tlast: frame_end
//  cfg_    | write     | we                | addr: register index; wdata: value
//
//  One pixel per clock is taken while the output side keeps up; a result leaves
//  after the pixel that completes its window by way of the RAM read, window
//  shift, gradient register and output register.
//  After reset the line RAM is cleared one row per cycle: in_tready stays low
//  until every row is zero. Configuration writes are taken at any time.
//  A stalled output holds one result in the output register and one in a skid
//  entry; the pipeline stops only when both are full, and in_tready with it.
module sobel_edge_threshold
  import sed_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int IN_W      = ((PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input pixel stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // [PIXEL_BITS-1:0] pixel, rest zero
  input  logic                  in_tuser,   // [0] frame_start
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] edge_res, [11:1] magnitude, rest zero
  output logic                  out_tlast,  // frame_end
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int CMPW = ((AW > CFG_DIM_W) ? AW : CFG_DIM_W) + 1;

  // Configuration registers
  logic [CFG_DIM_W-1:0] width_r, height_r;
  logic [THRESH_W-1:0]  thresh_r;

  // Raster position of the next pixel
  logic [AW-1:0]        col_r;
  logic [CFG_DIM_W-1:0] row_r;

  // Stage 1: pixel waiting on its RAM read
  stg_ctrl_t             s1_ctrl_r;
  logic [AW-1:0]         s1_col_r;
  logic [PIXEL_BITS-1:0] s1_px_r;

  logic                  adv, clearing, in_acc;
  logic [AW-1:0]         col_cur;
  logic [CFG_DIM_W-1:0]  row_cur;
  logic [CMPW-1:0]       width_eff, col_p1;
  logic [CFG_DIM_W:0]    row_p1, height_x;
  logic                  emit, last, row_end;
  logic [2*PIXEL_BITS-1:0] rd_q;
  logic                  res_valid;
  res_t                  res, out_res;
  logic [PIXEL_BITS-1:0] px;

  assign px        = in_tdata[PIXEL_BITS-1:0];
  assign in_tready = adv && !clearing;
  assign in_acc    = in_tvalid && in_tready;

  // Configuration writes; unknown index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:    width_r  <= cfg_wdata[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT:   height_r <= cfg_wdata[CFG_DIM_W-1:0];
        REG_EDGE_THRESHOLD: thresh_r <= cfg_wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Position decode for the incoming pixel
  always_comb begin
    col_cur   = in_tuser ? '0 : col_r;
    row_cur   = in_tuser ? '0 : row_r;
    width_eff = (CMPW'(width_r) > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : CMPW'(width_r);
    col_p1    = CMPW'(col_cur) + 1'b1;
    row_p1    = {1'b0, row_cur} + 1'b1;
    height_x  = {1'b0, height_r};
    emit      = (row_cur >= CFG_DIM_W'(2)) && (CMPW'(col_cur) >= CMPW'(2)) &&
                (row_p1 <= height_x) && (col_p1 <= width_eff);
    last      = (row_p1 == height_x) && (col_p1 == width_eff);
    row_end   = col_p1 >= width_eff;
  end

  // Column and row counters, wrapping at row and frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= (row_p1 >= height_x) ? '0 : row_p1[CFG_DIM_W-1:0];
      end else begin
        col_r <= col_p1[AW-1:0];
        row_r <= row_cur;
      end
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r <= '0;
    end else if (adv) begin
      s1_ctrl_r.valid <= in_acc;
      s1_ctrl_r.emit  <= emit;
      s1_ctrl_r.last  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r <= col_cur;
      s1_px_r  <= px;
    end
  end

  // Line RAM: read at accept, write back {row above, new pixel} from stage 1 as it advances
  sed_line_mem #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (col_cur),
    .rd_data  (rd_q),
    .wr_en    (adv && s1_ctrl_r.valid),
    .wr_addr  (s1_col_r),
    .wr_data  ({rd_q[PIXEL_BITS-1:0], s1_px_r}),
    .clearing (clearing)
  );

  sed_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s1_ctrl   (s1_ctrl_r),
    .px        (s1_px_r),
    .above     (rd_q[PIXEL_BITS-1:0]),
    .above2    (rd_q[2*PIXEL_BITS-1:PIXEL_BITS]),
    .thresh    (thresh_r),
    .res_valid (res_valid),
    .res       (res)
  );

  sed_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_data  (res),
    .room       (adv),
    .out_valid  (out_tvalid),
    .out_data   (out_res),
    .out_ready  (out_tready)
  );

  assign out_tdata = OUT_DATA_W'({out_res.magnitude, out_res.edge_res});
  assign out_tlast = out_res.frame_end;

  // Pipeline stalls only with a result already waiting at the output
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> out_tvalid)
    else $error("pipeline stalled with no result at the output");

  // Nothing moves through the pipeline during the RAM clear
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (!s1_ctrl_r.valid && !out_tvalid))
    else $error("pipeline active during line RAM clear");

  // A frame start pixel is placed at column zero
  a_frame_start_col: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser) |=> (s1_col_r == '0))
    else $error("frame start pixel not at column zero");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sobel_edge_threshold: edge predictor, pixel and result drivers.
module tb;
  import sed_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned STIM_ITEMS   = 1850;
  localparam int          DRAIN_CYCLES = 12;

  typedef enum int {FR_CLEAN, FR_NO_START, FR_TRUNC, FR_RESTART} frame_kind_t;
  typedef enum int {PX_NOISE, PX_BINARY, PX_SMOOTH, PX_RAMP} pix_style_t;

  typedef struct {
    logic [7:0] pixel;
    logic       start;
  } pix_item_t;

  // Sobel predictor plus the queue of edge results still owed by the block
  class EdgeScoreboard;
    localparam int MAX_REPORTS = 10;

    logic [CFG_DIM_W-1:0] img_w, img_h;
    logic [THRESH_W-1:0]  thresh;
    logic [7:0]           line_mem [2*MAX_WIDTH_DEF];
    logic [7:0]           win [3][3];
    logic [CFG_DIM_W-1:0] col_cnt, row_cnt;
    res_t                 edge_results_q[$];
    int n_pixels, n_results, n_edges, n_frame_ends, n_errors;

    function new();
      img_w   = WIDTH_RST;
      img_h   = HEIGHT_RST;
      thresh  = THRESH_RST;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      col_cnt = '0;
      row_cnt = '0;
      n_pixels = 0; n_results = 0; n_edges = 0; n_frame_ends = 0; n_errors = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH:    img_w  = val[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT:   img_h  = val[CFG_DIM_W-1:0];
        REG_EDGE_THRESHOLD: thresh = val[THRESH_W-1:0];
        default: ;  // unmapped index: no effect
      endcase
    endfunction

    // One accepted pixel: shift the window, update line store, maybe owe a result
    function void note_pixel(logic [7:0] px, logic start);
      int unsigned eff_w, c, r;
      logic [7:0]  above, above2;
      int          gx, gy, mag, wt;
      res_t        want;
      n_pixels++;
      eff_w = (img_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : img_w;
      if (start) begin
        col_cnt = '0;
        row_cnt = '0;
      end
      c = col_cnt;
      r = row_cnt;
      if (c >= MAX_WIDTH_DEF) c = 0;
      above  = line_mem[c];
      above2 = line_mem[MAX_WIDTH_DEF + c];
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = above2;
      win[1][2] = above;
      win[2][2] = px;
      line_mem[MAX_WIDTH_DEF + c] = above;
      line_mem[c] = px;

      // interior centre: window complete
      if (r >= 2 && c >= 2 && r + 1 <= img_h && c + 1 <= eff_w) begin
        gx = 0;
        gy = 0;
        for (int k = 0; k < 3; k++) begin
          wt = (k == 1) ? 2 : 1;
          gx += wt * (int'(win[k][2]) - int'(win[k][0]));
          gy += wt * (int'(win[2][k]) - int'(win[0][k]));
        end
        mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
        want.edge_res  = (mag > int'(thresh));
        want.magnitude = (mag > MAG_MAX) ? MAG_W'(MAG_MAX) : MAG_W'(mag);
        want.frame_end = (r + 1 == img_h && c + 1 == eff_w);
        edge_results_q.push_back(want);
      end

      // raster counters
      if (c + 1 >= eff_w) begin
        col_cnt = '0;
        row_cnt = (r + 1 >= img_h) ? '0 : CFG_DIM_W'(r + 1);
      end else begin
        col_cnt = CFG_DIM_W'(c + 1);
        row_cnt = CFG_DIM_W'(r);
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
      res_t want;
      if (edge_results_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%t unexpected result: edge=%0d mag=%0d end=%0d",
                   $time, data[0], data[MAG_W:1], last);
        return;
      end
      want = edge_results_q.pop_front();
      n_results++;
      if (want.edge_res) n_edges++;
      if (want.frame_end) n_frame_ends++;
      if (data[0] !== want.edge_res || data[MAG_W:1] !== want.magnitude ||
          last !== want.frame_end) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%t mismatch: expected edge=%0d mag=%0d end=%0d, got edge=%0d mag=%0d end=%0d",
                   $time, want.edge_res, want.magnitude, want.frame_end,
                   data[0], data[MAG_W:1], last);
      end
    endfunction
  endclass

  // DUT signals
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  EdgeScoreboard sb;
  pix_item_t     pix_q[$];
  int unsigned   n_pushed = 0;
  int unsigned   n_settings = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;

  sobel_edge_threshold i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pixel driver: note each transaction, then offer the next pixel or idle
  always @(posedge clk) begin
    pix_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) sb.note_pixel(in_tdata, in_tuser);
      if (!in_tvalid || in_tready) begin
        if (pix_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pix_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.pixel;
          in_tuser  <= nxt.start;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: random back-pressure and checking
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // New register setting; idling pattern rotates with each setting
  task automatic apply_setting(input int unsigned w, input int unsigned h,
                               input int unsigned thr);
    case (n_settings % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
      default: begin send_idle_pct = 28; recv_stall_pct = 28; end
    endcase
    cfg_write(REG_IMAGE_WIDTH, w[CFG_DATA_W-1:0]);
    cfg_write(REG_IMAGE_HEIGHT, h[CFG_DATA_W-1:0]);
    cfg_write(REG_EDGE_THRESHOLD, thr[CFG_DATA_W-1:0]);
    if ($urandom_range(2) == 0) cfg_write(REG_UNUSED, CFG_DATA_W'($urandom()));
    n_settings++;
  endtask

  task automatic push_pixel(input logic [7:0] px, input logic start);
    pix_q.push_back('{pixel: px, start: start});
    n_pushed++;
  endtask

  // Queue one frame of up to n pixels, possibly malformed
  task automatic push_frame(input int n, input frame_kind_t kind);
    int         len, restart_at, base, v;
    pix_style_t style;
    logic       st;
    style      = pix_style_t'($urandom_range(3));
    base       = $urandom_range(255);
    len        = n;
    restart_at = -1;
    if (kind == FR_TRUNC && n > 1) len = $urandom_range(n - 1, 1);
    if (kind == FR_RESTART && n > 1) restart_at = $urandom_range(n - 1, 1);
    for (int i = 0; i < len; i++) begin
      st = (i == 0 && kind != FR_NO_START) || (i == restart_at);
      case (style)
        PX_NOISE:  v = $urandom_range(255);
        PX_BINARY: v = $urandom_range(1) ? 255 : 0;
        PX_SMOOTH: begin
          v = base + int'($urandom_range(16)) - 8;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
        end
        default:   v = (base + i * 7) & 8'hFF;
      endcase
      push_pixel(v[7:0], st);
    end
  endtask

  // Wait until every pixel is taken and every result seen, then let the pipe empty
  task automatic wait_idle();
    do @(posedge clk); while (sb.n_pixels != n_pushed || sb.edge_results_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    logic [7:0]  peak_win [9];
    logic [7:0]  flat_win [16];
    int unsigned w, h, th, nfr, sel;
    frame_kind_t fk;
    peak_win = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd77, 8'd255, 8'd0, 8'd255, 8'd255};
    flat_win = '{8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200,
                 8'd200, 8'd200, 8'd200, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame, largest reachable magnitude equal to the threshold: no edge
    apply_setting(3, 3, 1530);
    foreach (peak_win[i]) push_pixel(peak_win[i], i == 0);
    wait_idle();

    // Zero threshold: flat window gives magnitude zero and no edge, the rest edges
    apply_setting(4, 4, 0);
    foreach (flat_win[i]) push_pixel(flat_win[i], i == 0);
    wait_idle();

    // Full line store width
    apply_setting(MAX_WIDTH_DEF, 3, $urandom_range(2047));
    push_frame(3 * MAX_WIDTH_DEF, FR_CLEAN);
    wait_idle();

    // Width register beyond the line store: rows end at the store size
    apply_setting($urandom_range(511, MAX_WIDTH_DEF + 1), 3, $urandom_range(700, 60));
    push_frame(2 * MAX_WIDTH_DEF + 12, FR_CLEAN);
    wait_idle();

    // Tall frame, only its top part
    apply_setting(3, 256, $urandom_range(700, 60));
    push_frame(30, FR_CLEAN);
    wait_idle();

    // Degenerate width and height: no results at all
    apply_setting($urandom_range(1), 4, 0);
    repeat (14) push_pixel(8'($urandom_range(255)), 1'($urandom_range(1)));
    wait_idle();
    apply_setting(5, $urandom_range(1), 0);
    repeat (15) push_pixel(8'($urandom_range(255)), 1'($urandom_range(1)));
    wait_idle();

    // Random settings, mostly clean frames with some malformed ones
    while (n_pushed < STIM_ITEMS) begin
      w   = ($urandom_range(9) < 7) ? $urandom_range(8, 3) : $urandom_range(40, 9);
      h   = (w > 8) ? $urandom_range(4, 3) : $urandom_range(7, 3);
      nfr = (w > 8) ? 1 : $urandom_range(3, 1);
      case ($urandom_range(9))
        0:       th = 0;
        1:       th = 2047;
        2:       th = $urandom_range(2047);
        default: th = $urandom_range(700, 60);
      endcase
      apply_setting(w, h, th);
      repeat (nfr) begin
        sel = $urandom_range(99);
        if (sel < 75)      fk = FR_CLEAN;
        else if (sel < 85) fk = FR_NO_START;
        else if (sel < 93) fk = FR_TRUNC;
        else               fk = FR_RESTART;
        push_frame(w * h, fk);
      end
      wait_idle();
    end

    $display("Covered %0d pixels over %0d register settings with four idling patterns",
             sb.n_pixels, n_settings);
    $display("Checked %0d results: %0d edges, %0d frame ends, %0d mismatches",
             sb.n_results, sb.n_edges, sb.n_frame_ends, sb.n_errors);
    if (sb.n_errors == 0 && sb.edge_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout: %0d of %0d pixels taken, %0d results outstanding",
             sb.n_pixels, n_pushed, sb.edge_results_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
